/* hdl/vera_pkg.sv */
// Shared types and codes for the variable-entry ring allocator.
`default_nettype none

package vera_pkg;

    localparam int SIZE_W = 17;   // request size and capacity field width
    localparam int OFFS_W = 16;   // entry offset field width
    localparam int RSZ_W  = 18;   // request size after rounding up to 8

    typedef enum logic [2:0] {
        CMD_RESERVE = 3'd0,
        CMD_POP     = 3'd1,
        CMD_PEEK    = 3'd2,
        CMD_QUERY   = 3'd3,
        CMD_NEXT    = 3'd4,
        CMD_CLEAR   = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOSPACE = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_END     = 3'd3,
        ST_BAD     = 3'd4
    } status_t;

    typedef struct packed {
        cmd_t              command;
        logic [SIZE_W-1:0] request_size;
        logic [OFFS_W-1:0] entry_offset;
        logic              from_front;
    } item_t;

    typedef struct packed {
        status_t           status;
        logic [OFFS_W-1:0] offset;
    } result_t;

endpackage

`default_nettype wire

/* hdl/vera_exec.sv */
// Command decode and next-state logic for one item of the ring allocator.
`default_nettype none

module vera_exec #(
    parameter int PW = 17
) (
    input  wire  logic [PW-1:0]      cap,
    input  wire  logic [PW-1:0]      rd,
    input  wire  logic [PW-1:0]      wr,
    input  wire  logic [PW-1:0]      wend,
    input  wire  vera_pkg::item_t    item,
    output logic [PW-1:0]            rd_next,
    output logic [PW-1:0]            wr_next,
    output logic [PW-1:0]            wend_next,
    output vera_pkg::result_t        result
);

    localparam int XW = ((PW > vera_pkg::RSZ_W) ? PW : vera_pkg::RSZ_W) + 1;

    logic [vera_pkg::RSZ_W-1:0] sz_sum;
    logic [vera_pkg::RSZ_W-1:0] sz;
    logic                       sz_zero;
    logic                       empty;
    logic                       at_wend;
    logic [PW-1:0]              front;
    logic                       r_le_w;
    logic                       hard_full;
    logic                       fits_start;
    logic [PW-1:0]              gap;
    logic                       fit_none;
    logic                       fit_wrap;
    logic [PW-1:0]              pop_base;
    logic [XW-1:0]              pop_sum;
    logic [XW-1:0]              nxt;

    always_comb begin
        sz_sum     = {1'b0, item.request_size} + vera_pkg::RSZ_W'(7);
        sz         = {sz_sum[vera_pkg::RSZ_W-1:3], 3'b000};
        sz_zero    = (sz == '0);
        empty      = (rd == wr);
        at_wend    = (rd == wend);
        front      = at_wend ? '0 : rd;
        r_le_w     = (rd <= wr);
        hard_full  = (XW'(sz) + XW'(wr)) >= XW'(cap);
        fits_start = XW'(sz) < XW'(rd);
        gap        = rd - wr;
        fit_none   = r_le_w ? (hard_full && !fits_start) : (XW'(sz) >= XW'(gap));
        fit_wrap   = r_le_w && hard_full && fits_start;
        pop_base   = at_wend ? '0 : rd;
        pop_sum    = XW'(pop_base) + XW'(sz);
        nxt        = XW'(item.entry_offset) + XW'(sz);
    end

    always_comb begin
        rd_next       = rd;
        wr_next       = wr;
        wend_next     = wend;
        result.status = vera_pkg::ST_OK;
        result.offset = '0;
        unique case (item.command)
            vera_pkg::CMD_RESERVE: begin
                if (sz_zero) begin
                    result.status = vera_pkg::ST_BAD;
                end else if (fit_none) begin
                    result.status = vera_pkg::ST_NOSPACE;
                end else if (fit_wrap) begin
                    wend_next = wr;
                    wr_next   = PW'(sz);
                end else begin
                    result.offset = vera_pkg::OFFS_W'(wr);
                    wr_next       = PW'(XW'(wr) + XW'(sz));
                end
            end
            vera_pkg::CMD_POP: begin
                if (sz_zero || empty) begin
                    result.status = vera_pkg::ST_BAD;
                end else begin
                    if (at_wend) begin
                        wend_next = cap;
                    end
                    rd_next = (pop_sum > XW'(cap)) ? cap : PW'(pop_sum);
                end
            end
            vera_pkg::CMD_PEEK: begin
                if (empty) begin
                    result.status = vera_pkg::ST_EMPTY;
                end else begin
                    result.offset = vera_pkg::OFFS_W'(front);
                end
            end
            vera_pkg::CMD_QUERY: begin
                if (sz_zero) begin
                    result.status = vera_pkg::ST_BAD;
                end else if (fit_none) begin
                    result.status = vera_pkg::ST_NOSPACE;
                end
            end
            vera_pkg::CMD_NEXT: begin
                if (empty) begin
                    result.status = vera_pkg::ST_EMPTY;
                end else if (item.from_front) begin
                    result.offset = vera_pkg::OFFS_W'(front);
                end else if (sz_zero) begin
                    result.status = vera_pkg::ST_BAD;
                end else if (nxt == XW'(wr)) begin
                    result.status = vera_pkg::ST_END;
                end else if (nxt > XW'(wend)) begin
                    result.status = vera_pkg::ST_BAD;
                end else if (nxt == XW'(wend)) begin
                    result.offset = '0;
                end else begin
                    result.offset = vera_pkg::OFFS_W'(nxt);
                end
            end
            vera_pkg::CMD_CLEAR: begin
                rd_next   = '0;
                wr_next   = '0;
                wend_next = cap;
            end
            default: begin
                result.status = vera_pkg::ST_BAD;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/variable_entry_ring_allocator.sv */
// Top level of the variable-entry ring allocator: item and result registers, ring state.
// Each item is held in the item register and its result is registered in the result register.
// Throughput: one item per cycle; the input and result registers stall together
// only when the result is not taken.
// Reset (aresetn low, synchronous): ring empty, soft end and capacity at the
// limited default; a capacity write reinitializes the ring as clear does.
`default_nettype none

module variable_entry_ring_allocator #(
    parameter int MAX_BYTES = 65536
) (
    input  wire  logic                          aclk,
    input  wire  logic                          aresetn,

    input  wire  logic                          cfg_wr_en,
    input  wire  logic [vera_pkg::SIZE_W-1:0]   cfg_wr_data,

    input  wire  logic                          s_valid,
    output logic                                s_ready,
    input  wire  logic [2:0]                    s_command,
    input  wire  logic [vera_pkg::SIZE_W-1:0]   s_request_size,
    input  wire  logic [vera_pkg::OFFS_W-1:0]   s_entry_offset,
    input  wire  logic                          s_from_front,

    output logic                                m_valid,
    input  wire  logic                          m_ready,
    output logic [2:0]                          m_status,
    output logic [vera_pkg::OFFS_W-1:0]         m_offset
);

    localparam int FIELD_MAX = (1 << vera_pkg::SIZE_W) - 1;
    localparam int CAP_MAX   = (MAX_BYTES < FIELD_MAX) ? MAX_BYTES : FIELD_MAX;
    localparam int PW        = $clog2(CAP_MAX + 1);
    localparam int CAP_DFLT  = ((65536 > CAP_MAX) ? CAP_MAX : 65536) & ~7;
    localparam logic [PW-1:0] CAP_RST = PW'((CAP_DFLT < 8) ? 8 : CAP_DFLT);
    localparam logic [PW-1:0] CAP_MIN = PW'(8);

    logic [PW-1:0]      cap_reg, cap_next;
    logic [PW-1:0]      rd_reg, rd_next;
    logic [PW-1:0]      wr_reg, wr_next;
    logic [PW-1:0]      wend_reg, wend_next;
    logic               in_vld_reg;
    vera_pkg::item_t    item_reg;
    logic               out_vld_reg;
    vera_pkg::result_t  result_reg;

    logic [PW-1:0]      exe_rd, exe_wr, exe_wend;
    vera_pkg::result_t  exe_result;
    logic               adv;
    logic [PW-1:0]      lim;
    logic [PW-1:0]      lim8;

    assign adv     = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || adv;

    // capacity write value: limited, floored to 8, at least 8
    always_comb begin
        lim  = (cfg_wr_data > vera_pkg::SIZE_W'(CAP_MAX)) ? PW'(CAP_MAX) : PW'(cfg_wr_data);
        lim8 = {lim[PW-1:3], 3'b000};
        if (lim8 < CAP_MIN) begin
            lim8 = CAP_MIN;
        end
    end

    vera_exec #(
        .PW (PW)
    ) u_exec (
        .cap       (cap_reg),
        .rd        (rd_reg),
        .wr        (wr_reg),
        .wend      (wend_reg),
        .item      (item_reg),
        .rd_next   (exe_rd),
        .wr_next   (exe_wr),
        .wend_next (exe_wend),
        .result    (exe_result)
    );

    always_comb begin
        cap_next  = cap_reg;
        rd_next   = rd_reg;
        wr_next   = wr_reg;
        wend_next = wend_reg;
        if (cfg_wr_en) begin
            cap_next  = lim8;
            rd_next   = '0;
            wr_next   = '0;
            wend_next = lim8;
        end else if (adv) begin
            rd_next   = exe_rd;
            wr_next   = exe_wr;
            wend_next = exe_wend;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= CAP_RST;
            rd_reg      <= '0;
            wr_reg      <= '0;
            wend_reg    <= CAP_RST;
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            cap_reg     <= cap_next;
            rd_reg      <= rd_next;
            wr_reg      <= wr_next;
            wend_reg    <= wend_next;
            in_vld_reg  <= (s_valid && s_ready) || (in_vld_reg && !adv);
            out_vld_reg <= adv || (out_vld_reg && !m_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.command      <= vera_pkg::cmd_t'(s_command);
            item_reg.request_size <= s_request_size;
            item_reg.entry_offset <= s_entry_offset;
            item_reg.from_front   <= s_from_front;
        end
        if (adv) begin
            result_reg <= exe_result;
        end
    end

    assign m_valid  = out_vld_reg;
    assign m_status = result_reg.status;
    assign m_offset = result_reg.offset;

    a_wr_below_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_reg < cap_reg)
        else $error("write offset reached capacity");

    a_rd_wend_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_reg <= cap_reg) && (wend_reg <= cap_reg))
        else $error("read offset or soft end beyond capacity");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && !cfg_wr_en && item_reg.command == vera_pkg::CMD_CLEAR)
        |=> (rd_reg == '0) && (wr_reg == '0) && (wend_reg == cap_reg))
        else $error("clear did not reinitialize the ring");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> m_valid)
        else $error("processed item produced no result");

endmodule

`default_nettype wire

/* bench/tb_variable_entry_ring_allocator.sv */
// Self-checking testbench for the variable-entry ring allocator.
`timescale 1ns / 100ps

module tb_variable_entry_ring_allocator;

    localparam int SIZE_W          = vera_pkg::SIZE_W;
    localparam int OFFS_W          = vera_pkg::OFFS_W;
    localparam int MAX_BYTES       = 65536;
    localparam int N_CAPS          = 9;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int HOLD_LEN        = 300;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 400000;

    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;

    localparam int FIT_NONE = 0;
    localparam int FIT_HERE = 1;
    localparam int FIT_WRAP = 2;

    typedef struct packed {
        logic [2:0]        command;
        logic [SIZE_W-1:0] size;
        logic [OFFS_W-1:0] eoff;
        logic              front;
    } alloc_req_t;

    class ring_scoreboard;
        int unsigned         cap_bytes;
        int unsigned         rd_pos;
        int unsigned         wr_pos;
        int unsigned         soft_end;
        vera_pkg::result_t   expected_q[$];
        vera_pkg::status_t   last_status;
        int unsigned         last_offset;
        int unsigned         errors;
        int unsigned         accepted;
        int unsigned         checked;
        int unsigned         wraps;
        int unsigned         nospace_cnt;
        int unsigned         end_cnt;
        int unsigned         bad_cnt;

        function new();
            set_capacity(17'h10000);
        endfunction

        function void reinit();
            rd_pos   = 0;
            wr_pos   = 0;
            soft_end = cap_bytes;
        endfunction

        function void set_capacity(logic [SIZE_W-1:0] raw);
            int unsigned c;
            c = 32'(raw);
            if (c > MAX_BYTES) c = MAX_BYTES;
            c = c & ~32'd7;
            if (c < 8) c = 8;
            cap_bytes = c;
            reinit();
        endfunction

        function int fit_kind(int unsigned sz);
            if (rd_pos <= wr_pos) begin
                if (sz + wr_pos >= cap_bytes) return (sz >= rd_pos) ? FIT_NONE : FIT_WRAP;
                return FIT_HERE;
            end
            return (sz >= rd_pos - wr_pos) ? FIT_NONE : FIT_HERE;
        endfunction

        function int unsigned front_offset();
            return (rd_pos == soft_end) ? 0 : rd_pos;
        endfunction

        function void note_item(alloc_req_t it);
            int unsigned         sz;
            int unsigned         nxt;
            int unsigned         r;
            int unsigned         off;
            int                  f;
            bit                  empty;
            vera_pkg::status_t   st;
            vera_pkg::result_t   res;
            sz    = (32'(it.size) + 32'd7) & ~32'd7;
            empty = (rd_pos == wr_pos);
            st    = vera_pkg::ST_OK;
            off   = 0;
            case (it.command)
                vera_pkg::CMD_RESERVE: begin
                    if (sz == 0) begin
                        st = vera_pkg::ST_BAD;
                    end else begin
                        f = fit_kind(sz);
                        if (f == FIT_NONE) begin
                            st = vera_pkg::ST_NOSPACE;
                        end else begin
                            if (f == FIT_WRAP) begin
                                soft_end = wr_pos;
                                wr_pos   = 0;
                                wraps++;
                            end
                            off    = wr_pos;
                            wr_pos = wr_pos + sz;
                        end
                    end
                end
                vera_pkg::CMD_POP: begin
                    if (sz == 0 || empty) begin
                        st = vera_pkg::ST_BAD;
                    end else begin
                        r = rd_pos;
                        if (rd_pos == soft_end) begin
                            r        = 0;
                            soft_end = cap_bytes;
                        end
                        r = r + sz;
                        if (r > cap_bytes) r = cap_bytes;
                        rd_pos = r;
                    end
                end
                vera_pkg::CMD_PEEK: begin
                    if (empty) st = vera_pkg::ST_EMPTY;
                    else off = front_offset();
                end
                vera_pkg::CMD_QUERY: begin
                    if (sz == 0) st = vera_pkg::ST_BAD;
                    else if (fit_kind(sz) == FIT_NONE) st = vera_pkg::ST_NOSPACE;
                end
                vera_pkg::CMD_NEXT: begin
                    if (empty) begin
                        st = vera_pkg::ST_EMPTY;
                    end else if (it.front) begin
                        off = front_offset();
                    end else if (sz == 0) begin
                        st = vera_pkg::ST_BAD;
                    end else begin
                        nxt = 32'(it.eoff) + sz;
                        if (nxt == wr_pos) st = vera_pkg::ST_END;
                        else if (nxt > soft_end) st = vera_pkg::ST_BAD;
                        else off = (nxt == soft_end) ? 0 : nxt;
                    end
                end
                vera_pkg::CMD_CLEAR: reinit();
                default: st = vera_pkg::ST_BAD;
            endcase
            if (st == vera_pkg::ST_NOSPACE) nospace_cnt++;
            if (st == vera_pkg::ST_END) end_cnt++;
            if (st == vera_pkg::ST_BAD) bad_cnt++;
            res.status = st;
            res.offset = off[OFFS_W-1:0];
            expected_q.push_back(res);
            last_status = st;
            last_offset = off;
            accepted++;
        endfunction

        function void check_result(logic [2:0] st, logic [OFFS_W-1:0] off);
            vera_pkg::result_t exp_res;
            if (expected_q.size() == 0) begin
                $error("result with no item waiting: status %0d offset %0d", st, off);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            checked++;
            if (st !== exp_res.status) begin
                $error("status: expected %0d, got %0d", exp_res.status, st);
                errors++;
            end
            if (off !== exp_res.offset) begin
                $error("offset: expected %0d, got %0d", exp_res.offset, off);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [SIZE_W-1:0]   cfg_wr_data;
    logic                s_valid;
    logic                s_ready;
    logic [2:0]          s_command;
    logic [SIZE_W-1:0]   s_request_size;
    logic [OFFS_W-1:0]   s_entry_offset;
    logic                s_from_front;
    logic                m_valid;
    logic                m_ready;
    logic [2:0]          m_status;
    logic [OFFS_W-1:0]   m_offset;

    ring_scoreboard sb = new();

    bit          quiet;
    bit          hold_req;
    int unsigned hold_left;
    int unsigned cycle_count;
    int unsigned live_off[$];
    int unsigned live_len[$];
    bit          resync_needed;

    logic [SIZE_W-1:0] cap_plan [N_CAPS] = '{17'd0, 17'd64, 17'd260, 17'd1001, 17'd4096,
                                              17'd131071, 17'd27, 17'd65535, 17'd200};

    variable_entry_ring_allocator #(.MAX_BYTES(MAX_BYTES)) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_request_size (s_request_size),
        .s_entry_offset (s_entry_offset),
        .s_from_front   (s_from_front),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_offset       (m_offset)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic bit take_gap();
        return !quiet && ($urandom_range(0, 99) < 31);
    endfunction

    function automatic alloc_req_t make_req(logic [2:0] cmd, logic [SIZE_W-1:0] size,
                                            logic [OFFS_W-1:0] eoff, logic front);
        alloc_req_t r;
        r.command = cmd;
        r.size    = size;
        r.eoff    = eoff;
        r.front   = front;
        return r;
    endfunction

    function automatic logic [SIZE_W-1:0] raw_of(int unsigned rounded);
        return SIZE_W'(rounded - $urandom_range(0, 7));
    endfunction

    function automatic logic [SIZE_W-1:0] rnd_size();
        return SIZE_W'($urandom);
    endfunction

    function automatic logic [OFFS_W-1:0] rnd_offs();
        return OFFS_W'($urandom);
    endfunction

    function automatic logic rnd_bit();
        return 1'($urandom);
    endfunction

    task automatic send_item(input alloc_req_t req);
        @(negedge aclk);
        while (take_gap()) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_command      <= req.command;
        s_request_size <= req.size;
        s_entry_offset <= req.eoff;
        s_from_front   <= req.front;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_item(req);
    endtask

    task automatic write_capacity(input logic [SIZE_W-1:0] raw);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= raw;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_capacity(raw);
        live_off.delete();
        live_len.delete();
        resync_needed = 0;
    endtask

    task automatic run_directed();
        send_item(make_req(vera_pkg::CMD_PEEK,    17'd0,      16'd0,      1'b0));
        send_item(make_req(vera_pkg::CMD_NEXT,    17'd8,      16'd0,      1'b1));
        send_item(make_req(vera_pkg::CMD_POP,     17'd8,      16'd0,      1'b0));
        send_item(make_req(vera_pkg::CMD_RESERVE, 17'd0,      16'd0,      1'b0));
        send_item(make_req(vera_pkg::CMD_QUERY,   17'd0,      16'd0,      1'b0));
        send_item(make_req(vera_pkg::CMD_QUERY,   17'd65536,  16'd0,      1'b0));
        send_item(make_req(vera_pkg::CMD_RESERVE, 17'd1,      16'd0,      1'b0));
        send_item(make_req(vera_pkg::CMD_RESERVE, 17'h1FFFF,  16'd0,      1'b0));
        send_item(make_req(vera_pkg::CMD_NEXT,    17'd8,      16'hFFFF,   1'b1));
        send_item(make_req(vera_pkg::CMD_NEXT,    17'd0,      16'd0,      1'b0));
        send_item(make_req(vera_pkg::CMD_NEXT,    17'd8,      16'd0,      1'b0));
        send_item(make_req(vera_pkg::CMD_NEXT,    17'd8,      16'hFFFF,   1'b0));
        send_item(make_req(CMD_SPARE_A,           17'd8,      16'd0,      1'b0));
        send_item(make_req(CMD_SPARE_B,           17'h1FFFF,  16'hFFFF,   1'b1));
        send_item(make_req(vera_pkg::CMD_RESERVE, 17'd8,      16'd0,      1'b0));
        send_item(make_req(vera_pkg::CMD_RESERVE, 17'd65511,  16'd0,      1'b0));
        send_item(make_req(vera_pkg::CMD_POP,     17'd8,      16'd0,      1'b0));
        send_item(make_req(vera_pkg::CMD_POP,     17'd3,      16'd0,      1'b0));
        // fits only at the start: soft end moves to the write offset
        send_item(make_req(vera_pkg::CMD_RESERVE, 17'd8,      16'd0,      1'b0));
        send_item(make_req(vera_pkg::CMD_PEEK,    17'd0,      16'd0,      1'b0));
        send_item(make_req(vera_pkg::CMD_NEXT,    17'd65512,  16'd16,     1'b0));
        send_item(make_req(vera_pkg::CMD_NEXT,    17'd8,      16'd0,      1'b0));
        send_item(make_req(vera_pkg::CMD_POP,     17'd65512,  16'd0,      1'b0));
        send_item(make_req(vera_pkg::CMD_POP,     17'd8,      16'd0,      1'b0));
        send_item(make_req(vera_pkg::CMD_RESERVE, 17'd8,      16'd0,      1'b0));
        // pop past the write offset saturates at capacity
        send_item(make_req(vera_pkg::CMD_POP,     17'h1FFFF,  16'd0,      1'b0));
        send_item(make_req(vera_pkg::CMD_CLEAR,   17'd0,      16'd0,      1'b0));
    endtask

    task automatic random_item();
        int unsigned roll;
        int unsigned hi;
        int unsigned idx;
        alloc_req_t  req;
        roll = $urandom_range(0, 99);
        hi   = (sb.cap_bytes / 3 < 8) ? 8 : sb.cap_bytes / 3;
        if (resync_needed) begin
            send_item(make_req(vera_pkg::CMD_CLEAR, rnd_size(), rnd_offs(), rnd_bit()));
            live_off.delete();
            live_len.delete();
            resync_needed = 0;
        end else if (roll < 42) begin
            req = make_req(vera_pkg::CMD_RESERVE, ($urandom_range(0, 9) == 0) ?
                           SIZE_W'($urandom_range(1, 32'h1FFFF)) :
                           SIZE_W'($urandom_range(1, hi)),
                           rnd_offs(), rnd_bit());
            send_item(req);
            if (sb.last_status == vera_pkg::ST_OK) begin
                live_off.push_back(sb.last_offset);
                live_len.push_back((32'(req.size) + 32'd7) & ~32'd7);
            end
        end else if (roll < 72) begin
            if (live_len.size() != 0) begin
                send_item(make_req(vera_pkg::CMD_POP, raw_of(live_len[0]), rnd_offs(),
                                   rnd_bit()));
                void'(live_off.pop_front());
                void'(live_len.pop_front());
            end else begin
                send_item(make_req(vera_pkg::CMD_POP, SIZE_W'($urandom_range(0, hi)),
                                   rnd_offs(), rnd_bit()));
            end
        end else if (roll < 78) begin
            send_item(make_req(vera_pkg::CMD_PEEK, rnd_size(), rnd_offs(), rnd_bit()));
        end else if (roll < 84) begin
            send_item(make_req(vera_pkg::CMD_QUERY, SIZE_W'($urandom_range(0, hi)),
                               rnd_offs(), rnd_bit()));
        end else if (roll < 93) begin
            if (live_len.size() != 0 && $urandom_range(0, 3) != 0) begin
                idx = $urandom_range(0, live_len.size() - 1);
                send_item(make_req(vera_pkg::CMD_NEXT, raw_of(live_len[idx]),
                                   OFFS_W'(live_off[idx]), 1'b0));
            end else begin
                send_item(make_req(vera_pkg::CMD_NEXT, rnd_size(), rnd_offs(), 1'b1));
            end
        end else begin
            req = make_req(3'($urandom_range(0, 7)), rnd_size(), rnd_offs(), rnd_bit());
            send_item(req);
            if (req.command == vera_pkg::CMD_RESERVE && sb.last_status == vera_pkg::ST_OK) begin
                live_off.push_back(sb.last_offset);
                live_len.push_back((32'(req.size) + 32'd7) & ~32'd7);
            end else if (req.command == vera_pkg::CMD_POP &&
                         sb.last_status == vera_pkg::ST_OK) begin
                resync_needed = 1;
            end else if (req.command == vera_pkg::CMD_CLEAR) begin
                live_off.delete();
                live_len.delete();
            end
        end
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 0;
                hold_left = HOLD_LEN;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !take_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_status, m_offset);
    end

    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_valid        = 1'b0;
        s_command      = vera_pkg::CMD_PEEK;
        s_request_size = '0;
        s_entry_offset = '0;
        s_from_front   = 1'b0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        run_directed();
        for (int p = 0; p <= N_CAPS; p++) begin
            if (p > 0) write_capacity(cap_plan[p-1]);
            quiet = (p == 3);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (k == 50 && (p == 5 || p == 8)) hold_req = 1;
                random_item();
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Covered %0d items over %0d capacity settings, %0d results checked.",
                 sb.accepted, N_CAPS + 1, sb.checked);
        $display("Ring wrapped %0d times; %0d no-space, %0d end and %0d bad-request answers.",
                 sb.wraps, sb.nospace_cnt, sb.end_cnt, sb.bad_cnt);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* variable_entry_ring_allocator.f */
hdl/vera_pkg.sv
hdl/vera_exec.sv
hdl/variable_entry_ring_allocator.sv
bench/tb_variable_entry_ring_allocator.sv
